// ===== src/knt_pkg.sv =====
// ----------------------------------------------------------------------------
// knt_pkg
// Shared types, constants and helpers for the keyword/number tokenizer.
// ----------------------------------------------------------------------------
package knt_pkg;

    localparam int MAX_TOKENS     = 64;
    localparam int MAX_NAME_CHARS = 32;
    localparam int FIFO_DEPTH     = 4;

    typedef enum logic [2:0] {
        KIND_NONE   = 3'd0,
        KIND_NUMBER = 3'd1,
        KIND_PLUS   = 3'd2,
        KIND_MINUS  = 3'd3,
        KIND_EQUALS = 3'd4,
        KIND_SEMI   = 3'd5,
        KIND_RETURN = 3'd6,
        KIND_END    = 3'd7
    } kind_t;

    // One accepted character causes up to two results: an optional flushed
    // token, then an optional semicolon or end item.
    typedef struct packed {
        logic        first_v;
        kind_t       first_kind;
        logic [31:0] first_value;
        logic [6:0]  first_index;
        logic        second_v;
        kind_t       second_kind;
        logic [6:0]  second_index;
    } event_t;

    // Expected character for each step of the "return" match.
    function automatic logic [7:0] kw_char(input logic [3:0] idx);
        logic [7:0] ch;
        unique case (idx)
            4'd0:    ch = 8'h72; // r
            4'd1:    ch = 8'h65; // e
            4'd2:    ch = 8'h74; // t
            4'd3:    ch = 8'h75; // u
            4'd4:    ch = 8'h72; // r
            4'd5:    ch = 8'h6E; // n
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

endpackage

// ===== src/knt_front.sv =====
// ----------------------------------------------------------------------------
// knt_front
// Character front end: tracks the pending token, classifies it on a
// delimiter or end of text, and produces at most one event per accepted character.
// ----------------------------------------------------------------------------
module knt_front (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            accept,
    input  logic [7:0]      char_code,
    input  logic            end_of_text,
    output logic            ev_valid,
    output knt_pkg::event_t ev
);

    typedef enum logic [1:0] {
        NP_LEAD   = 2'd0,
        NP_SIGN   = 2'd1,
        NP_DIGITS = 2'd2,
        NP_BAD    = 2'd3
    } np_t;

    localparam logic [3:0] KP_START  = 4'd0;
    localparam logic [3:0] KP_RETURN = 4'd6;
    localparam logic [3:0] KP_EQ     = 4'd7;
    localparam logic [3:0] KP_PLUS   = 4'd8;
    localparam logic [3:0] KP_MINUS  = 4'd9;
    localparam logic [3:0] KP_DEAD   = 4'd15;

    localparam logic [4:0] LEN_LIMIT = 5'(knt_pkg::MAX_NAME_CHARS - 1);
    localparam logic [6:0] CNT_MAX   = 7'(knt_pkg::MAX_TOKENS);

    logic [4:0]  len_reg,  len_next;
    logic [3:0]  kp_reg,   kp_next,   kp_take;
    np_t         np_reg,   np_next,   np_take;
    logic        neg_reg,  neg_next,  neg_take;
    logic [31:0] mag_reg,  mag_next,  mag_take;
    logic        sat_reg,  sat_next,  sat_take;
    logic [6:0]  cnt_reg,  cnt_next;
    logic        tfull_reg, tfull_next;

    logic              is_delim;
    logic              is_digit;
    logic [3:0]        dval;
    logic [35:0]       acc;
    logic [31:0]       acc_mag;
    logic              acc_sat;
    knt_pkg::kind_t    flush_kind;
    logic [31:0]       flush_value;
    logic              flush;
    logic              semi;
    logic [6:0]        cnt1;

    assign is_delim = (char_code == 8'h20) || (char_code == 8'h0A) ||
                      (char_code == 8'h09) || (char_code == 8'h3B);
    assign is_digit = (char_code >= 8'h30) && (char_code <= 8'h39);
    assign dval     = 4'(char_code - 8'h30);

    // magnitude * 10 + digit, capped at 2^31
    always_comb
    begin
        acc = ({4'b0, mag_reg} << 3) + ({4'b0, mag_reg} << 1) + 36'(dval);
        if (acc >= 36'h0_8000_0000)
        begin
            acc_mag = 32'h8000_0000;
            acc_sat = 1'b1;
        end
        else
        begin
            acc_mag = acc[31:0];
            acc_sat = sat_reg;
        end
    end

    // Update of the match and number state for a kept character
    always_comb
    begin
        if (kp_reg == KP_START)
        begin
            unique case (char_code)
                8'h72:   kp_take = 4'd1;
                8'h3D:   kp_take = KP_EQ;
                8'h2B:   kp_take = KP_PLUS;
                8'h2D:   kp_take = KP_MINUS;
                default: kp_take = KP_DEAD;
            endcase
        end
        else if (kp_reg < KP_RETURN && char_code == knt_pkg::kw_char(kp_reg))
        begin
            kp_take = kp_reg + 4'd1;
        end
        else
        begin
            kp_take = KP_DEAD;
        end

        np_take  = np_reg;
        neg_take = neg_reg;
        mag_take = mag_reg;
        sat_take = sat_reg;
        unique case (np_reg)
            NP_LEAD:
            begin
                if (char_code == 8'h0B || char_code == 8'h0C || char_code == 8'h0D)
                begin
                    np_take = NP_LEAD;
                end
                else if (char_code == 8'h2B)
                begin
                    np_take = NP_SIGN;
                end
                else if (char_code == 8'h2D)
                begin
                    np_take  = NP_SIGN;
                    neg_take = 1'b1;
                end
                else if (is_digit)
                begin
                    np_take  = NP_DIGITS;
                    mag_take = acc_mag;
                    sat_take = acc_sat;
                end
                else
                begin
                    np_take = NP_BAD;
                end
            end
            NP_SIGN, NP_DIGITS:
            begin
                if (is_digit)
                begin
                    np_take  = NP_DIGITS;
                    mag_take = acc_mag;
                    sat_take = acc_sat;
                end
                else
                begin
                    np_take = NP_BAD;
                end
            end
            NP_BAD:
            begin
                np_take = NP_BAD;
            end
        endcase
    end

    // Class and value of the pending token
    always_comb
    begin
        flush_value = 32'd0;
        if (kp_reg == KP_RETURN)
            flush_kind = knt_pkg::KIND_RETURN;
        else if (kp_reg == KP_EQ)
            flush_kind = knt_pkg::KIND_EQUALS;
        else if (kp_reg == KP_PLUS)
            flush_kind = knt_pkg::KIND_PLUS;
        else if (kp_reg == KP_MINUS)
            flush_kind = knt_pkg::KIND_MINUS;
        else if (np_reg == NP_DIGITS)
        begin
            flush_kind = knt_pkg::KIND_NUMBER;
            if (neg_reg)
                flush_value = sat_reg ? 32'h8000_0000 : (32'd0 - mag_reg);
            else
                flush_value = (sat_reg || mag_reg[31]) ? 32'h7FFF_FFFF : mag_reg;
        end
        else
            flush_kind = knt_pkg::KIND_NONE;
    end

    always_comb
    begin
        len_next   = len_reg;
        kp_next    = kp_reg;
        np_next    = np_reg;
        neg_next   = neg_reg;
        mag_next   = mag_reg;
        sat_next   = sat_reg;
        cnt_next   = cnt_reg;
        tfull_next = tfull_reg;
        ev_valid   = 1'b0;
        flush      = 1'b0;
        semi       = 1'b0;
        cnt1       = cnt_reg;

        ev.first_v      = 1'b0;
        ev.first_kind   = flush_kind;
        ev.first_value  = flush_value;
        ev.first_index  = cnt_reg;
        ev.second_v     = 1'b0;
        ev.second_kind  = knt_pkg::KIND_SEMI;
        ev.second_index = cnt_reg;

        if (accept)
        begin
            if (end_of_text)
            begin
                flush           = !tfull_reg && (len_reg != 5'd0);
                ev.first_v      = flush;
                ev.second_v     = 1'b1;
                ev.second_kind  = knt_pkg::KIND_END;
                ev.second_index = cnt_reg + 7'(flush);
                ev_valid        = 1'b1;
                len_next   = 5'd0;
                kp_next    = KP_START;
                np_next    = NP_LEAD;
                neg_next   = 1'b0;
                mag_next   = 32'd0;
                sat_next   = 1'b0;
                cnt_next   = 7'd0;
                tfull_next = 1'b0;
            end
            else if (tfull_reg)
            begin
                // drop everything until end of text
            end
            else if (!is_delim)
            begin
                if (len_reg < LEN_LIMIT)
                begin
                    len_next = len_reg + 5'd1;
                    kp_next  = kp_take;
                    np_next  = np_take;
                    neg_next = neg_take;
                    mag_next = mag_take;
                    sat_next = sat_take;
                end
            end
            else
            begin
                flush           = (len_reg != 5'd0);
                cnt1            = cnt_reg + 7'(flush);
                semi            = (char_code == 8'h3B) && (cnt1 < CNT_MAX);
                ev.first_v      = flush;
                ev.second_v     = semi;
                ev.second_index = cnt1;
                ev_valid        = flush || semi;
                cnt_next        = cnt1 + 7'(semi);
                tfull_next      = (cnt_next >= CNT_MAX);
                len_next        = 5'd0;
                kp_next         = KP_START;
                np_next         = NP_LEAD;
                neg_next        = 1'b0;
                mag_next        = 32'd0;
                sat_next        = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg   <= 5'd0;
            kp_reg    <= KP_START;
            np_reg    <= NP_LEAD;
            neg_reg   <= 1'b0;
            mag_reg   <= 32'd0;
            sat_reg   <= 1'b0;
            cnt_reg   <= 7'd0;
            tfull_reg <= 1'b0;
        end
        else
        begin
            len_reg   <= len_next;
            kp_reg    <= kp_next;
            np_reg    <= np_next;
            neg_reg   <= neg_next;
            mag_reg   <= mag_next;
            sat_reg   <= sat_next;
            cnt_reg   <= cnt_next;
            tfull_reg <= tfull_next;
        end
    end

endmodule

// ===== src/knt_fifo.sv =====
// ----------------------------------------------------------------------------
// knt_fifo
// Short event queue between the front end and the result stage.
// ----------------------------------------------------------------------------
module knt_fifo (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            wr_en,
    input  knt_pkg::event_t wr_data,
    output logic            full,
    input  logic            rd_en,
    output knt_pkg::event_t rd_data,
    output logic            empty
);

    localparam int PTR_W = $clog2(knt_pkg::FIFO_DEPTH);
    localparam int CNT_W = $clog2(knt_pkg::FIFO_DEPTH + 1);

    knt_pkg::event_t mem_reg [knt_pkg::FIFO_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg,    cnt_next;
    logic             do_wr, do_rd;

    assign full    = (cnt_reg == CNT_W'(knt_pkg::FIFO_DEPTH));
    assign empty   = (cnt_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_wr)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(knt_pkg::FIFO_DEPTH - 1)) ? '0
                          : wr_ptr_reg + PTR_W'(1);
        if (do_rd)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(knt_pkg::FIFO_DEPTH - 1)) ? '0
                          : rd_ptr_reg + PTR_W'(1);
        cnt_next = cnt_reg + CNT_W'(do_wr) - CNT_W'(do_rd);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
            mem_reg[wr_ptr_reg] <= wr_data;
    end

endmodule

// ===== src/knt_back.sv =====
// ----------------------------------------------------------------------------
// knt_back
// Result stage: holds one event and hands out its one or two result items.
// ----------------------------------------------------------------------------
module knt_back (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            ev_empty,
    input  knt_pkg::event_t ev_data,
    output logic            ev_pop,
    input  logic            pop,
    output logic            empty,
    output logic [6:0]      token_index,
    output logic [2:0]      token_kind,
    output logic [31:0]     number_value,
    output logic            last_of_run
);

    knt_pkg::event_t cur_reg, cur_next;
    logic            cur_v_reg, cur_v_next;
    logic            sel_reg, sel_next;
    logic            taken, finish, advance, load;

    assign taken   = cur_v_reg && pop;
    assign finish  = taken && (sel_reg || !cur_reg.second_v);
    assign advance = taken && !sel_reg && cur_reg.second_v;
    assign load    = !ev_empty && (!cur_v_reg || finish);
    assign ev_pop  = load;

    assign empty        = !cur_v_reg;
    assign token_index  = sel_reg ? cur_reg.second_index : cur_reg.first_index;
    assign token_kind   = sel_reg ? cur_reg.second_kind : cur_reg.first_kind;
    assign number_value = sel_reg ? 32'd0 : cur_reg.first_value;
    assign last_of_run  = sel_reg || !cur_reg.second_v;

    always_comb
    begin
        cur_next   = cur_reg;
        cur_v_next = cur_v_reg;
        sel_next   = sel_reg;
        if (load)
        begin
            cur_next   = ev_data;
            cur_v_next = 1'b1;
            sel_next   = !ev_data.first_v;
        end
        else if (finish)
        begin
            cur_v_next = 1'b0;
        end
        else if (advance)
        begin
            sel_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_v_reg <= 1'b0;
            sel_reg   <= 1'b0;
        end
        else
        begin
            cur_v_reg <= cur_v_next;
            sel_reg   <= sel_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
    end

endmodule

// ===== src/keyword_number_tokenizer.sv =====
// ----------------------------------------------------------------------------
// keyword_number_tokenizer
// Splits a character stream into return/=/+/-/;/number tokens and streams
// them out, followed by an end item that carries the token count.
// ----------------------------------------------------------------------------
// Throughput: one character per cycle while full is low; one result item leaves per pop.
// Path: a character's result is written into the event queue, then loaded into
//   the result register, which drives the result ports.
// Bursts: a 4-entry event queue absorbs characters that yield two items.
// Reset: rst_n clears the token state, the count and the queue at once;
//   the block can take characters once rst_n is released.
// ----------------------------------------------------------------------------
module keyword_number_tokenizer (
    input  logic               clk,
    input  logic               rst_n,
    // character side
    input  logic               push,
    output logic               full,
    input  logic [7:0]         char_code,
    input  logic               end_of_text,
    // result side
    output logic               empty,
    input  logic               pop,
    output logic [6:0]         token_index,
    output logic [2:0]         token_kind,
    output logic signed [31:0] number_value,
    output logic               last_of_run
);

    // Front end to queue
    logic            accept;
    logic            ev_valid;
    knt_pkg::event_t ev;

    // Queue to result stage
    logic            q_full;
    logic            q_empty;
    logic            q_pop;
    knt_pkg::event_t q_data;

    logic [31:0]     value_bits;

    // Take a character whenever the queue has room; the front end never
    // writes more than one event per character.
    assign full   = q_full;
    assign accept = push && !q_full;

    knt_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .char_code   (char_code),
        .end_of_text (end_of_text),
        .ev_valid    (ev_valid),
        .ev          (ev)
    );

    // Decouple the character side from the result side
    knt_fifo u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (ev_valid),
        .wr_data (ev),
        .full    (q_full),
        .rd_en   (q_pop),
        .rd_data (q_data),
        .empty   (q_empty)
    );

    // Hand out the items of each event in order, marking the last one
    knt_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .ev_empty     (q_empty),
        .ev_data      (q_data),
        .ev_pop       (q_pop),
        .pop          (pop),
        .empty        (empty),
        .token_index  (token_index),
        .token_kind   (token_kind),
        .number_value (value_bits),
        .last_of_run  (last_of_run)
    );

    assign number_value = $signed(value_bits);

endmodule

// ===== src/knt_checker.sv =====
// ----------------------------------------------------------------------------
// knt_checker
// Port-level checks on the tokenizer result stream.
// ----------------------------------------------------------------------------
module knt_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               full,
    input logic               empty,
    input logic               pop,
    input logic [6:0]         token_index,
    input logic [2:0]         token_kind,
    input logic signed [31:0] number_value,
    input logic               last_of_run
);

    // End item always closes the run of its character
    a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && token_kind == knt_pkg::KIND_END) |-> last_of_run)
        else $error("end item without last_of_run");

    // Only number tokens carry a value
    a_value_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && token_kind != knt_pkg::KIND_NUMBER) |-> (number_value == 32'sd0))
        else $error("nonzero value on non-number item");

    // Index never passes the token limit
    a_index_bound: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (token_index <= 7'(knt_pkg::MAX_TOKENS)))
        else $error("token index beyond limit");

    // Nothing to read and room for characters right after reset
    a_reset_empty: assert property (@(posedge clk)
        !rst_n |=> (empty && !full))
        else $error("result queue not empty after reset");

    // A stalled item holds
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(token_kind) && $stable(token_index)))
        else $error("stalled item changed");

endmodule

bind keyword_number_tokenizer knt_checker u_knt_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .full         (full),
    .empty        (empty),
    .pop          (pop),
    .token_index  (token_index),
    .token_kind   (token_kind),
    .number_value (number_value),
    .last_of_run  (last_of_run)
);
